[src/prime_two_squares_split_defines.svh]
// Assertion macros shared by the two-squares splitter RTL.
`ifndef PRIME_TWO_SQUARES_SPLIT_DEFINES_SVH
`define PRIME_TWO_SQUARES_SPLIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PTS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pts_pkg.sv]
// Package with the widths, types and constants of the two-squares splitter.
`timescale 1ns / 1ps
package pts_pkg;

	localparam int NUM_WIDTH_DEF = 16;
	localparam int N_WIDTH       = 16;
	localparam int ROOT_WIDTH    = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int CNT_WIDTH     = $clog2(MAX_RESULTS + 1);

	typedef logic [N_WIDTH-1:0]    n_t;
	typedef logic [ROOT_WIDTH-1:0] root_t;

	typedef struct packed {
		root_t small_root;
		root_t large_root;
		logic  found;
		logic  last;
	} res_t;

endpackage

[src/pts_in_if.sv]
// Input channel: one number to split per transfer.
`timescale 1ns / 1ps
interface pts_in_if;
	logic        valid;
	logic        ready;
	pts_pkg::n_t n;

	modport source (output valid, output n, input ready);
	modport sink (input valid, input n, output ready);
endinterface

[src/pts_out_if.sv]
// Output channel: one root pair with its flags per transfer.
`timescale 1ns / 1ps
interface pts_out_if;
	logic           valid;
	logic           ready;
	pts_pkg::root_t small_root;
	pts_pkg::root_t large_root;
	logic           found;
	logic           last;

	modport source (output valid, output small_root, output large_root, output found,
		output last, input ready);
	modport sink (input valid, input small_root, input large_root, input found,
		input last, output ready);
endinterface

[src/prime_two_squares_split.sv]
// Top level of the two-squares splitter: candidate scan, serial Euclid unit, output stage.
//
//   channel | direction | payload                                  | transfer when
//   --------+-----------+------------------------------------------+------------------------
//   num     | in        | n                                        | num.valid && num.ready
//   split   | out       | small_root, large_root, found, last      | split.valid && split.ready
//
// A number is taken only while the sequencer is idle; its results follow, the last one marked.
// The scan tests one candidate t per cycle while it runs; on a hit it pauses while the Euclid
// steps and the closing of the hit run on the shared bit-serial multiply / remainder unit.
// Reset clears the sequencer and both result registers; no clearing pass is needed.
// A stalled output holds its result; the sequencer then waits before handing over the next one.
`timescale 1ns / 1ps
`include "prime_two_squares_split_defines.svh"
module prime_two_squares_split #(
	parameter int NUM_WIDTH = pts_pkg::NUM_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pts_in_if.sink    num,
	pts_out_if.source split
);

	localparam int W     = NUM_WIDTH;
	localparam int STEPW = $clog2(NUM_WIDTH + 1);
	localparam int CW    = pts_pkg::CNT_WIDTH;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCAN = 4'd1;  // one candidate per cycle
	localparam logic [3:0] ST_ECHK = 4'd2;  // Euclid loop head
	localparam logic [3:0] ST_ESQ  = 4'd3;  // square of the current remainder
	localparam logic [3:0] ST_EMOD = 4'd4;  // next remainder
	localparam logic [3:0] ST_FSQ  = 4'd5;  // square of the previous remainder
	localparam logic [3:0] ST_FMOD = 4'd6;  // second root of the pair
	localparam logic [3:0] ST_PAIR = 4'd7;  // hand a pair to the result stage
	localparam logic [3:0] ST_DONE = 4'd8;  // final result of this number

	logic [3:0]       state_q;

	// Scan registers: t, t*t mod n, and (2t+1) mod n kept in step with t.
	logic [W-1:0]     n_q, half_q, t_q, sq_q, d_q;
	// Euclid registers.
	logic [W-1:0]     prev_q, cur_q, sec_q;
	// Shared serial unit: hi_q/lo_q form the shift pair, opd_q is multiplicand or divisor.
	logic [W-1:0]     hi_q, lo_q, opd_q;
	logic [STEPW-1:0] step_q;

	logic [CW-1:0]    cnt_q;
	pts_pkg::res_t    pend_q, out_q;
	logic             pend_v_q, out_v_q;

	logic [W-1:0]     n_in;
	logic [W:0]       sq_sum, d_sum, mul_sum, div_trial, div_new;
	logic [W-1:0]     sq_nxt, d_nxt, pair_min, pair_max;
	logic             div_ge, sq_ge_n, sq_gt_n, hit, t_end, out_free, unit_done, out_load;
	logic [CW-1:0]    cnt_nxt;
	pts_pkg::res_t    pair_res, empty_res, pend_last;

	assign n_in = W'(num.n);

	// Incremental candidate test: (t+1)^2 = t^2 + (2t+1), each sum reduced once.
	assign sq_sum = {1'b0, sq_q} + {1'b0, d_q};
	assign sq_nxt = (sq_sum >= {1'b0, n_q}) ? W'(sq_sum - {1'b0, n_q}) : W'(sq_sum);
	assign d_sum  = {1'b0, d_q} + (W+1)'(2);
	assign d_nxt  = (d_sum >= {1'b0, n_q}) ? W'(d_sum - {1'b0, n_q}) : W'(d_sum);
	assign hit    = (sq_q == n_q - W'(1));
	assign t_end  = (t_q > half_q);

	// Serial multiply step: add the multiplicand when the low bit is set, shift right.
	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opd_q} : '0);
	// Restoring remainder step: bring in one dividend bit, subtract when it fits.
	assign div_trial = {hi_q, lo_q[W-1]};
	assign div_ge    = (div_trial >= {1'b0, opd_q});
	assign div_new   = div_ge ? (div_trial - {1'b0, opd_q}) : div_trial;
	assign unit_done = (step_q == '0);

	// Product compares against n once the unit has finished a square.
	assign sq_ge_n = (|hi_q) || (lo_q >= n_q);
	assign sq_gt_n = (|hi_q) || (lo_q > n_q);

	assign pair_min = (cur_q < sec_q) ? cur_q : sec_q;
	assign pair_max = (cur_q < sec_q) ? sec_q : cur_q;

	always_comb begin
		pair_res.small_root = pts_pkg::ROOT_WIDTH'(pair_min);
		pair_res.large_root = pts_pkg::ROOT_WIDTH'(pair_max);
		pair_res.found      = 1'b1;
		pair_res.last       = 1'b0;
		empty_res.small_root = '0;
		empty_res.large_root = '0;
		empty_res.found      = 1'b0;
		empty_res.last       = 1'b1;
		// The pending pair as it leaves when it closes the number.
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	assign cnt_nxt  = cnt_q + CW'(1);
	assign out_free = !out_v_q || split.ready;
	// The output register takes a new result when a pending pair is pushed out by a newer
	// one, or when the number closes.
	assign out_load = out_free && ((state_q == ST_PAIR && pend_v_q) || state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			half_q   <= '0;
			t_q      <= '0;
			sq_q     <= '0;
			d_q      <= '0;
			prev_q   <= '0;
			cur_q    <= '0;
			sec_q    <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			opd_q    <= '0;
			step_q   <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			out_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (split.ready) begin
				out_v_q <= 1'b0;
			end

			// The serial unit steps whenever it holds work.
			if (!unit_done) begin
				step_q <= step_q - STEPW'(1);
				if (state_q == ST_ESQ || state_q == ST_FSQ) begin
					hi_q <= mul_sum[W:1];
					lo_q <= {mul_sum[0], lo_q[W-1:1]};
				end else begin
					hi_q <= div_new[W-1:0];
					lo_q <= {lo_q[W-2:0], 1'b0};
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						n_q      <= n_in;
						half_q   <= n_in >> 1;
						t_q      <= W'(1);
						sq_q     <= W'(1);
						d_q      <= (n_in == W'(3)) ? '0 : W'(3);
						cnt_q    <= '0;
						pend_v_q <= (n_in == W'(2));
						if (n_in == W'(2)) begin
							pend_q.small_root <= pts_pkg::ROOT_WIDTH'(1);
							pend_q.large_root <= pts_pkg::ROOT_WIDTH'(1);
							pend_q.found      <= 1'b1;
							pend_q.last       <= 1'b0;
							state_q           <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (t_end) begin
						state_q <= ST_DONE;
					end else begin
						t_q  <= t_q + W'(1);
						sq_q <= sq_nxt;
						d_q  <= d_nxt;
						if (hit) begin
							prev_q  <= n_q;
							cur_q   <= t_q;
							state_q <= ST_ECHK;
						end
					end
				end
				ST_ECHK: begin
					hi_q   <= '0;
					step_q <= STEPW'(W);
					if (cur_q == '0) begin
						lo_q    <= prev_q;
						opd_q   <= prev_q;
						state_q <= ST_FSQ;
					end else begin
						lo_q    <= cur_q;
						opd_q   <= cur_q;
						state_q <= ST_ESQ;
					end
				end
				ST_ESQ: begin
					if (unit_done) begin
						hi_q   <= '0;
						lo_q   <= prev_q;
						step_q <= STEPW'(W);
						if (sq_ge_n) begin
							opd_q   <= cur_q;
							state_q <= ST_EMOD;
						end else begin
							opd_q   <= prev_q;
							state_q <= ST_FSQ;
						end
					end
				end
				ST_EMOD: begin
					if (unit_done) begin
						prev_q  <= cur_q;
						cur_q   <= hi_q;
						state_q <= ST_ECHK;
					end
				end
				ST_FSQ: begin
					if (unit_done) begin
						if (!sq_gt_n) begin
							state_q <= ST_SCAN;
						end else if (cur_q != '0) begin
							hi_q    <= '0;
							lo_q    <= prev_q;
							opd_q   <= cur_q;
							step_q  <= STEPW'(W);
							state_q <= ST_FMOD;
						end else begin
							sec_q   <= '0;
							state_q <= ST_PAIR;
						end
					end
				end
				ST_FMOD: begin
					if (unit_done) begin
						sec_q   <= hi_q;
						state_q <= ST_PAIR;
					end
				end
				ST_PAIR: begin
					// The pending pair moves on only once a newer one proves it is not last.
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_q <= pend_q;
						end
						pend_q   <= pair_res;
						pend_v_q <= 1'b1;
						cnt_q    <= cnt_nxt;
						state_q  <= (cnt_nxt == CW'(pts_pkg::MAX_RESULTS)) ? ST_DONE : ST_SCAN;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q    <= pend_v_q ? pend_last : empty_res;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign num.ready        = (state_q == ST_IDLE);
	assign split.valid      = out_v_q;
	assign split.small_root = out_q.small_root;
	assign split.large_root = out_q.large_root;
	assign split.found      = out_q.found;
	assign split.last       = out_q.last;

	// A pair never stays pending once the number is finished.
	`PTS_ASSERT_IMPLIES(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "pair left pending in idle")
	// The result count never passes the cap.
	`PTS_ASSERT_ALWAYS(a_cnt_cap, cnt_q <= CW'(pts_pkg::MAX_RESULTS), "result count over cap")
	// An empty answer is always the final result.
	`PTS_ASSERT_IMPLIES(a_empty_last, out_v_q && !out_q.found, out_q.last, "empty answer not last")
	// The remainder unit never runs with a zero divisor.
	`PTS_ASSERT_IMPLIES(a_div_nonzero, (state_q == ST_EMOD || state_q == ST_FMOD) && !unit_done,
		opd_q != '0, "remainder step with zero divisor")
	// Handing over a pair always leaves one pending.
	`PTS_ASSERT_NEXT(a_pair_pends, state_q == ST_PAIR && !pend_v_q, pend_v_q, "pair not captured")

endmodule
